// ===== hw/rtl/days_between_two_dates_top_assert.svh =====
// Assertion macros shared by the date difference block.
`ifndef DAYS_BETWEEN_TWO_DATES_TOP_ASSERT_SVH
`define DAYS_BETWEEN_TWO_DATES_TOP_ASSERT_SVH

// Implication checked at the same clock edge.
`define DDB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("date difference assertion failed");

// Implication whose consequent is checked later than its antecedent.
`define DDB_ASSERT_LATER(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("date difference latency assertion failed");

`endif

// ===== hw/rtl/ddb_pkg.sv =====
// Types, constants and the month offset table of the date difference block.
package ddb_pkg;

	localparam int CountW = 24;
	localparam int DiffW = 22;

	typedef logic signed [CountW-1:0] count_t;
	typedef logic [DiffW-1:0] diff_t;

	localparam logic [24:0] DIFF_MAX = 25'd4194303;

	// Reciprocal of 25 scaled by 2^17; exact for dividends below 4096.
	localparam logic [12:0] RECIP_25 = 13'd5243;
	localparam int RECIP_SHIFT = 17;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

	// Days in the months before the given one; out-of-range months clamp.
	function automatic logic [8:0] days_before_month(input logic [3:0] mon);
		logic [8:0] r;
		unique case (mon)
			4'd0, 4'd1: r = 9'd0;
			4'd2:  r = 9'd31;
			4'd3:  r = 9'd59;
			4'd4:  r = 9'd90;
			4'd5:  r = 9'd120;
			4'd6:  r = 9'd151;
			4'd7:  r = 9'd181;
			4'd8:  r = 9'd212;
			4'd9:  r = 9'd243;
			4'd10: r = 9'd273;
			4'd11: r = 9'd304;
			default: r = 9'd334;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/ddb_lane.sv =====
// One date lane: converts a date to its day count since 1 January of year 1.
module ddb_lane
	import ddb_pkg::*;
(
	input  logic        clk,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	output count_t      count
);

	logic [13:0] prev_year;
	logic [11:0] quarter;
	logic [11:0] year_quarter;
	logic [24:0] prod_cent;
	logic [24:0] prod_yq;
	logic [22:0] days_years;

	logic [22:0] p365_s1;
	logic [11:0] q4_s1;
	logic [7:0]  q100_s1;
	logic [11:0] y4_s1;
	logic [7:0]  yq25_s1;
	logic [3:0]  ylow_s1;
	logic        yzero_s1;
	logic [3:0]  mon_s1;
	logic [4:0]  day_s1;

	logic [11:0] rem25;
	logic        leap;
	logic [22:0] base;

	logic [22:0] base_s2;
	logic        leap_s2;
	logic [3:0]  mon_s2;
	logic [4:0]  day_s2;

	logic [CountW-1:0] total;
	count_t            count_s3;

	// Stage 1: earlier years times 365, and quarters divided by 25 by reciprocal.
	assign prev_year    = year - 14'd1;
	assign quarter      = prev_year[13:2];
	assign year_quarter = year[13:2];
	assign prod_cent    = quarter * RECIP_25;
	assign prod_yq      = year_quarter * RECIP_25;
	assign days_years   = prev_year * DAYS_PER_YEAR;

	always_ff @(posedge clk) begin
		p365_s1  <= days_years;
		q4_s1    <= quarter;
		q100_s1  <= prod_cent[RECIP_SHIFT+7:RECIP_SHIFT];
		y4_s1    <= year_quarter;
		yq25_s1  <= prod_yq[RECIP_SHIFT+7:RECIP_SHIFT];
		ylow_s1  <= year[3:0];
		yzero_s1 <= (year == 14'd0);
		mon_s1   <= month;
		day_s1   <= day;
	end

	// Stage 2: leap days of earlier years, and the leap flag of this year.
	// A year is a century when its quarter is a multiple of 25.
	assign rem25 = y4_s1 - ({4'd0, yq25_s1} * 12'd25);
	assign leap  = (ylow_s1[1:0] == 2'd0) && ((rem25 != 12'd0) || (ylow_s1[3:2] == 2'd0));
	assign base  = yzero_s1 ? 23'd0
		: p365_s1 + {11'd0, q4_s1} - {15'd0, q100_s1} + {17'd0, q100_s1[7:2]};

	always_ff @(posedge clk) begin
		base_s2 <= base;
		leap_s2 <= leap;
		mon_s2  <= mon_s1;
		day_s2  <= day_s1;
	end

	// Stage 3: month offset, leap day and day of month; day zero may go negative.
	assign total = {1'b0, base_s2} + {15'd0, days_before_month(mon_s2)}
		+ {23'd0, leap_s2 && (mon_s2 > 4'd2)} + {19'd0, day_s2} - 24'd1;

	always_ff @(posedge clk) begin
		count_s3 <= count_t'(total);
	end

	assign count = count_s3;

endmodule

// ===== hw/rtl/ddb_merge.sv =====
// Merging stage: absolute difference of the two lane counts, saturated to 22 bits.
module ddb_merge
	import ddb_pkg::*;
(
	input  logic   clk,
	input  count_t count_a,
	input  count_t count_b,
	output diff_t  day_difference
);

	logic [24:0] diff;
	logic [24:0] diff_s1;
	logic [24:0] mag;
	diff_t       day_difference_s2;

	assign diff = {count_a[CountW-1], count_a} - {count_b[CountW-1], count_b};

	always_ff @(posedge clk) begin
		diff_s1 <= diff;
	end

	assign mag = diff_s1[24] ? (25'd0 - diff_s1) : diff_s1;

	always_ff @(posedge clk) begin
		day_difference_s2 <= (mag > DIFF_MAX) ? {DiffW{1'b1}} : mag[DiffW-1:0];
	end

	assign day_difference = day_difference_s2;

endmodule

// ===== hw/rtl/days_between_two_dates_top.sv =====
// Date difference block: two conversion lanes, a merging stage and the command handshake.
// done is high in the same cycle that day_difference shows the result of the accepted word.
// Throughput: one word per cycle; busy stays low, so start may be held high every cycle.
// The latency is set by the five-deep pipeline; every stage takes a new word each cycle.
// Reset: arst_n clears the done strobe and the valid chain; data registers are not reset.
// The receiver cannot stall, so done and day_difference last exactly one cycle.
`include "days_between_two_dates_top_assert.svh"

module days_between_two_dates_top
	import ddb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [4:0]  day_a,
	input  logic [3:0]  month_a,
	input  logic [13:0] year_a,
	input  logic [4:0]  day_b,
	input  logic [3:0]  month_b,
	input  logic [13:0] year_b,
	output logic        done,
	output logic [21:0] day_difference
);

	count_t      count_a;
	count_t      count_b;
	logic [4:0]  valid_q;
	logic        same_month;
	logic        same_date;
	logic [21:0] day_gap;

	ddb_lane u_lane_a (
		.clk   (clk),
		.day   (day_a),
		.month (month_a),
		.year  (year_a),
		.count (count_a)
	);

	ddb_lane u_lane_b (
		.clk   (clk),
		.day   (day_b),
		.month (month_b),
		.year  (year_b),
		.count (count_b)
	);

	ddb_merge u_merge (
		.clk            (clk),
		.count_a        (count_a),
		.count_b        (count_b),
		.day_difference (day_difference)
	);

	// One valid bit follows each word through the five stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], start};
		end
	end

	assign busy = 1'b0;
	assign done = valid_q[4];

	assign same_month = (month_a == month_b) && (year_a == year_b);
	assign same_date  = same_month && (day_a == day_b);
	assign day_gap    = {17'd0, (day_a > day_b) ? (day_a - day_b) : (day_b - day_a)};

	`DDB_ASSERT_LATER(a_latency, clk, arst_n, start, 5, done)
	`DDB_ASSERT_IMPL(a_same_date, clk, arst_n, done && $past(same_date, 5),
		day_difference == 22'd0)
	`DDB_ASSERT_IMPL(a_same_month, clk, arst_n, done && $past(same_month, 5),
		day_difference == $past(day_gap, 5))

endmodule
